>>> sv/swm_pkg.sv
// ============================================================================
// swm_pkg
// Shared types and default constants for the sliding window maximum filter.
// ============================================================================
package swm_pkg;

    // Default sizing handed to the top level parameters
    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Width of the window length register
    localparam int WLEN_W = 7;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } swm_state_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic shift;   // load the neighbor's sample
        logic enable;  // cell lies inside the current window
    } swm_cell_ctrl_t;

endpackage

>>> sv/sliding_window_maximum.sv
// ============================================================================
// sliding_window_maximum
// Running maximum of the latest window_length signed samples, built as a
// shift chain of cells with a registered max wave running through it.
// ============================================================================
//
//  Channel  | Signals                           | Beat carries
//  ---------+-----------------------------------+--------------------------
//  input    | in_valid, in_ready                | sample, first
//  output   | out_valid, out_ready              | window_max
//  config   | cfg_valid, cfg_ready              | window_length
//
//  A beat that yields no result leaves the input ready for the next beat. A beat
//  that yields a result holds the input busy while the max wave passes one cell
//  per cycle through the chain, and then until the result is loaded into the
//  output register. A pending output only stalls the wave's hand-off.
//  Reset clears the controller, fill count and window length (to 1); no
//  clearing pass is needed.
//
module sliding_window_maximum #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input samples
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample,
    input  logic                            first,
    // results
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]  window_max,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swm_pkg::WLEN_W-1:0]      window_length
);

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int KW     = (FILL_W > swm_pkg::WLEN_W) ? FILL_W : swm_pkg::WLEN_W;

    swm_pkg::swm_state_t            state_reg, state_next;
    logic [FILL_W-1:0]              fill_reg, fill_next, fill_base;
    logic [FILL_W-1:0]              cnt_reg, cnt_next;
    logic [swm_pkg::WLEN_W-1:0]     wlen_reg, wlen_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg, out_data_next;

    logic                           accept;
    logic                           has_result;
    logic                           wave_done;
    logic                           load_out;
    logic [KW-1:0]                  k_ext, k_eff;

    logic signed [SAMPLE_WIDTH-1:0] smp_chain [MAX_WINDOW+1];
    logic signed [SAMPLE_WIDTH-1:0] acc_chain [MAX_WINDOW+1];

    // Handshakes
    assign in_ready  = (state_reg == swm_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Config register
    assign wlen_next = (cfg_valid && cfg_ready) ? window_length : wlen_reg;

    // Fill count, saturating at the chain depth
    always_comb
    begin
        fill_base = first ? '0 : fill_reg;
        if (fill_base < FILL_W'(MAX_WINDOW))
            fill_next = fill_base + 1'b1;
        else
            fill_next = fill_base;
        if (!accept)
            fill_next = fill_reg;
    end

    // Effective window: zero acts as one, clipped to the chain depth
    always_comb
    begin
        k_ext = KW'(wlen_reg);
        if (k_ext == '0)
            k_eff = KW'(1);
        else if (k_ext > KW'(MAX_WINDOW))
            k_eff = KW'(MAX_WINDOW);
        else
            k_eff = k_ext;
    end

    assign has_result = (KW'(fill_next) >= k_eff);

    // Cell chain: samples shift toward the old end, max wave runs alongside
    assign smp_chain[0] = sample;
    assign acc_chain[0] = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        swm_pkg::swm_cell_ctrl_t cell_ctrl;

        assign cell_ctrl.shift  = accept;
        assign cell_ctrl.enable = (i == 0) || (int'(wlen_reg) > i);

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .sample_in  (smp_chain[i]),
            .acc_in     (acc_chain[i]),
            .sample_out (smp_chain[i+1]),
            .acc_out    (acc_chain[i+1])
        );
    end

    // Sequencer: wait for the wave to settle, then hand the max to the output
    assign wave_done = (cnt_reg == FILL_W'(MAX_WINDOW));
    assign load_out  = (state_reg == swm_pkg::ST_RUN) && wave_done &&
                       (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && has_result)
                    state_next = swm_pkg::ST_RUN;
            end
            swm_pkg::ST_RUN:
            begin
                if (!wave_done)
                    cnt_next = cnt_reg + 1'b1;
                if (load_out)
                    state_next = swm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = swm_pkg::ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = acc_chain[MAX_WINDOW];
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swm_pkg::ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            wlen_reg      <= (swm_pkg::WLEN_W)'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            wlen_reg      <= wlen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign window_max = out_data_reg;

endmodule

>>> sv/swm_cell.sv
// ============================================================================
// swm_cell
// One cell of the max chain: holds one stored sample and a running maximum
// that it passes to the next cell every cycle.
// ============================================================================
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  swm_pkg::swm_cell_ctrl_t        ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic signed [SAMPLE_WIDTH-1:0] acc_in,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic signed [SAMPLE_WIDTH-1:0] acc_out
);

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_next;
    logic signed [SAMPLE_WIDTH-1:0] acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] acc_next;

    // Sample shifts in from the younger neighbor on an accepted beat
    assign sample_next = ctrl.shift ? sample_in : sample_reg;

    // Running max; cells outside the window pass the incoming value on
    assign acc_next = (ctrl.enable && (sample_reg > acc_in)) ? sample_reg : acc_in;

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        acc_reg    <= acc_next;
    end

    assign sample_out = sample_reg;
    assign acc_out    = acc_reg;

endmodule

>>> sv/swm_checker.sv
// ============================================================================
// swm_checker
// Port-level checks for the sliding window maximum filter.
// ============================================================================
module swm_checker #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] window_max
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(window_max))
        else $error("result changed while stalled");

    // Input side goes busy only because a beat was taken
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input went busy without an accepted beat");

    // A new result is shown exactly as the block frees its input
    a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready && $rose(in_ready))
        else $error("result appeared without the input side freeing");

    // The input frees only as a new result is loaded into a free output
    a_free_loads: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid && (!$past(out_valid) || $past(out_ready)))
        else $error("input freed without a result being loaded");

endmodule

bind sliding_window_maximum swm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_max (window_max)
);

>>> verif/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the sliding window maximum filter. Signed samples
// go in as directed and random sequences over a range of window lengths. A
// software ring of the latest samples predicts each window maximum. Random
// stalls hit both handshakes.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIN       = swm_pkg::MAX_WINDOW_DEF;
    localparam int SW            = swm_pkg::SAMPLE_WIDTH_DEF;
    localparam int WL_W          = swm_pkg::WLEN_W;
    // one max wave plus load, with margin
    localparam int SETTLE_CYCLES = MAX_WIN + 16;

    typedef struct {
        logic signed [SW-1:0] value;
        logic                 starts_seq;
    } sample_beat_t;

    // DUT connections
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic signed [SW-1:0]   sample        = '0;
    logic                   first         = 1'b0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic signed [SW-1:0]   window_max;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [WL_W-1:0]        window_length = '0;

    // stimulus and scoreboard
    sample_beat_t           sample_q[$];
    logic signed [SW-1:0]   window_max_q[$];
    int                     n_queued   = 0;
    int                     n_accepted = 0;
    int                     n_checked  = 0;
    int                     n_fail     = 0;
    int                     n_cfg      = 0;
    int                     gap_left   = 0;
    int                     stall_left = 0;
    logic                   idle_on    = 1'b1;

    // predictor state
    logic signed [SW-1:0]   ring [MAX_WIN];
    int unsigned            seq_fill   = 0;
    int unsigned            ring_wr    = 0;
    logic [WL_W-1:0]        wlen_cfg   = WL_W'(1);

    sliding_window_maximum u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .first         (first),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .window_max    (window_max),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length)
    );

    always #1 clk = ~clk;

    // zero maps to 1, anything above the ring depth saturates
    function automatic int unsigned clamp_window(input logic [WL_W-1:0] k);
        if (k == 0)
            return 1;
        if (k > MAX_WIN)
            return MAX_WIN;
        return int'(k);
    endfunction

    // Advance the ring by one sample and queue the window max if the
    // current sequence is long enough
    task automatic track_sample(input logic signed [SW-1:0] s, input logic starts);
        int unsigned          k;
        int unsigned          idx;
        logic signed [SW-1:0] best;
        if (starts)
            seq_fill = 0;
        ring[ring_wr] = s;
        ring_wr = (ring_wr + 1) % MAX_WIN;
        if (seq_fill < MAX_WIN)
            seq_fill++;
        k = clamp_window(wlen_cfg);
        if (seq_fill >= k)
        begin
            best = s;
            for (int i = 0; i < k; i++)
            begin
                idx = (ring_wr + MAX_WIN - 1 - i) % MAX_WIN;
                if (ring[idx] > best)
                    best = ring[idx];
            end
            window_max_q.insert(window_max_q.size(), best);
        end
    endtask

    task automatic queue_item(input logic signed [SW-1:0] v, input logic starts);
        sample_beat_t b;
        b.value      = v;
        b.starts_seq = starts;
        sample_q.insert(sample_q.size(), b);
        n_queued++;
    endtask

    // every queued beat taken and every result delivered
    task automatic wait_drained();
        while (!(n_accepted == n_queued && window_max_q.size() == 0))
            @(posedge clk);
    endtask

    // drained, then let any beat without a result finish inside the block
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window_length(input logic [WL_W-1:0] k);
        @(posedge clk);
        cfg_valid     <= 1'b1;
        window_length <= k;
        do
            @(posedge clk);
        while (!cfg_ready);
        wlen_cfg = k;
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    // Random sequences: mostly long enough to fill the window, some short
    // ones, a few without a start flag or with one dropped mid-stream
    task automatic gen_sequences(input int budget, input int unsigned k_eff, input logic cont);
        int                   n;
        int                   len;
        int                   style;
        logic signed [SW-1:0] v;
        logic                 f;
        n = 0;
        while (n < budget)
        begin
            if (k_eff > 1 && $urandom_range(0, 4) == 0)
                len = $urandom_range(1, k_eff - 1);
            else
                len = k_eff + $urandom_range(0, 12);
            // keep the phase at its budget
            if (len > budget - n)
                len = budget - n;
            style = $urandom_range(0, 4);
            v = SW'($urandom);
            for (int i = 0; i < len; i++)
            begin
                case (style)
                    0: v = SW'($urandom);
                    1:
                    begin
                        v = SW'($urandom_range(0, 8));
                        v = SW'(v - 4);
                    end
                    2: v = SW'(v - $urandom_range(0, 5));
                    3: v = SW'(v + $urandom_range(0, 5));
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0: v = 16'sh8000;
                            1: v = 16'sh7fff;
                            2: v = SW'($urandom);
                            default: ;
                        endcase
                    end
                endcase
                if (i == 0)
                    f = !(cont && n == 0) && $urandom_range(0, 9) != 0;
                else
                    f = $urandom_range(0, 49) == 0;
                queue_item(v, f);
                n++;
            end
        end
    endtask

    task automatic run_phase(input logic [WL_W-1:0] k, input int budget,
                             input logic idle, input logic cont);
        write_window_length(k);
        idle_on = idle;
        gen_sequences(budget, clamp_window(k), cont);
        settle();
    endtask

    // Input driver: hold each beat until taken, random gap bursts
    always @(posedge clk)
    begin : drive
        sample_beat_t beat;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_sample(sample, first);
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 3) == 0)
                begin
                    gap_left = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end
                else
                begin
                    beat = sample_q.pop_front();
                    sample   <= beat.value;
                    first    <= beat.starts_seq;
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Result monitor: compare each beat, stall in random bursts
    always @(posedge clk)
    begin : check
        logic signed [SW-1:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (window_max_q.size() == 0)
                begin
                    $error("window_max: unexpected result, expected none, actual %0d",
                           window_max);
                    n_fail++;
                end
                else
                begin
                    want = window_max_q.pop_front();
                    if (window_max !== want)
                    begin
                        $error("window_max mismatch: expected %0d, actual %0d",
                               want, window_max);
                        n_fail++;
                    end
                    n_checked++;
                end
            end
            if (!idle_on)
            begin
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Main sequence
    initial
    begin
        for (int i = 0; i < MAX_WIN; i++)
            ring[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window of 1 straight out of reset, sample extremes
        queue_item(16'sh7fff, 1'b1);
        queue_item(16'sh8000, 1'b0);
        queue_item(-16'sd1, 1'b0);
        queue_item(16'sd0, 1'b0);
        settle();

        // zero length behaves as 1
        write_window_length(0);
        queue_item(16'sd5, 1'b1);
        queue_item(-16'sd5, 1'b0);
        settle();

        // short sequence gives nothing, then the max drops out of the window
        write_window_length(3);
        queue_item(16'sd100, 1'b1);
        queue_item(16'sd200, 1'b0);
        queue_item(16'sh8000, 1'b1);
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh7fff, 1'b0);
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh8000, 1'b0);
        queue_item(16'sh8000, 1'b0);
        settle();

        // longer window mid-sequence, fill count carries over
        write_window_length(5);
        queue_item(-16'sd7, 1'b0);
        queue_item(16'sd1, 1'b0);
        settle();

        // random phases over many window lengths
        run_phase(64, 70, 1'b1, 1'b0);
        run_phase(2, 50, 1'b1, 1'b1);
        run_phase(127, 70, 1'b1, 1'b0);
        run_phase(1, 40, 1'b1, 1'b1);

        // sender holds off mid-sequence until all results are back
        write_window_length(17);
        idle_on = 1'b1;
        gen_sequences(30, 17, 1'b0);
        wait_drained();
        gen_sequences(30, 17, 1'b1);
        settle();

        run_phase(0, 40, 1'b1, 1'b0);
        run_phase(65, 70, 1'b1, 1'b1);
        run_phase(8, 50, 1'b0, 1'b0);
        run_phase(WL_W'($urandom_range(1, MAX_WIN)), 60, 1'b1, 1'b0);
        // closing stretch at full rate
        run_phase(4, 40, 1'b0, 1'b1);

        if (window_max_q.size() != 0)
        begin
            $error("window_max: %0d expected results never arrived", window_max_q.size());
            n_fail++;
        end
        $display("Covered %0d samples and %0d window max beats across %0d window settings",
                 n_accepted, n_checked, n_cfg);
        $display("Mismatches or stray beats: %0d", n_fail);
        if (n_fail == 0)
            $display("sliding_window_maximum verification clean");
        else
            $display("sliding_window_maximum verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("sliding_window_maximum verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/swm_pkg.sv
sv/swm_cell.sv
sv/sliding_window_maximum.sv
sv/swm_checker.sv
verif/testbench.sv
